// ----- sv/ahe_pkg.sv -----
// Shared types and constants for the Ascon-Hash engine.
package ahe_pkg;

  localparam int PERM_ROUNDS  = 12;
  localparam int DIGEST_WORDS = 4;
  localparam int TOTAL_ROUNDS = 12;

  localparam int RND_W = 4;
  localparam int SQZ_W = 3;

  localparam logic [RND_W-1:0] FIRST_RND = RND_W'(TOTAL_ROUNDS - PERM_ROUNDS);
  localparam logic [RND_W-1:0] LAST_RND  = RND_W'(PERM_ROUNDS - 1);
  localparam logic [SQZ_W-1:0] LAST_SQZ  = SQZ_W'(DIGEST_WORDS - 1);

  localparam logic [63:0] HASH_IV  = 64'h0040_0c00_0000_0100;
  localparam logic [63:0] PAD_TOP  = 64'h8000_0000_0000_0000;

  typedef logic [4:0][63:0] sponge_t;

endpackage

// ----- sv/ahe_round.sv -----
// One round of the Ascon permutation: constant add, S-box layer, linear layer.
module ahe_round (
  input  ahe_pkg::sponge_t x_in,
  input  logic [7:0]       rc,
  output ahe_pkg::sponge_t x_out
);
  import ahe_pkg::*;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
    rotr = (v >> n) | (v << (64 - n));
  endfunction

  logic [63:0] a0, a1, a2, a3, a4;
  logic [63:0] b0, b1, b2, b3, b4;
  logic [63:0] c0, c1, c2, c3, c4;

  always_comb begin
    // Constant addition and S-box input mixing
    a2 = x_in[2] ^ {56'd0, rc};
    a0 = x_in[0] ^ x_in[4];
    a4 = x_in[4] ^ x_in[3];
    a2 = a2 ^ x_in[1];
    a1 = x_in[1];
    a3 = x_in[3];
    // Chi-like nonlinear layer
    b0 = a0 ^ (~a1 & a2);
    b1 = a1 ^ (~a2 & a3);
    b2 = a2 ^ (~a3 & a4);
    b3 = a3 ^ (~a4 & a0);
    b4 = a4 ^ (~a0 & a1);
    // Output mixing
    c1 = b1 ^ b0;
    c0 = b0 ^ b4;
    c3 = b3 ^ b2;
    c2 = ~b2;
    c4 = b4;
    // Linear diffusion
    x_out[0] = c0 ^ rotr(c0, 19) ^ rotr(c0, 28);
    x_out[1] = c1 ^ rotr(c1, 61) ^ rotr(c1, 39);
    x_out[2] = c2 ^ rotr(c2, 1)  ^ rotr(c2, 6);
    x_out[3] = c3 ^ rotr(c3, 10) ^ rotr(c3, 17);
    x_out[4] = c4 ^ rotr(c4, 7)  ^ rotr(c4, 41);
  end

endmodule

// ----- sv/ascon_hash_engine.sv -----
// Top level of the Ascon-Hash engine: sponge state, round sequencer, stream ports.
//
// Ascon-Hash with a 64-bit rate over a 320-bit sponge, built around one
// round unit that is reused for every permutation round, one round per
// cycle. An input item carries a big-endian message word, a valid-byte
// count and a last flag. A non-last word is absorbed and permuted, and the
// engine returns to idle before the next item is taken. A last word
// with fewer than eight valid bytes is padded and permuted once; a full
// last word costs a second permutation for the padding-only block. Four
// digest words then leave on the output stream, each followed by a
// permutation before the next one, and after the final word the engine
// re-runs the 12-round initialization before it takes the next message.
// After reset the same initialization runs before in_tready rises.
// in_tready is low whenever a permutation runs or a digest word waits on
// the output; the round unit is the one resource shared by all of these
// permutations.
module ascon_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] message_word, [67:64] byte_count, [71:68] zero
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] hash_word
  output logic        out_tlast   // hash_last
);
  import ahe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;

  // What follows the permutation that is running
  typedef enum logic [1:0] {
    NX_IDLE,
    NX_PAD,
    NX_SQUEEZE
  } next_t;

  state_t           st_r, st_nxt;
  next_t            after_r, after_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [SQZ_W-1:0] sqz_r, sqz_nxt;
  sponge_t          x_r, x_nxt;
  sponge_t          x_rnd;
  logic [RND_W-1:0] rnd_idx;
  logic [7:0]       rc;

  logic [63:0] in_word;
  logic [3:0]  in_cnt;
  logic [6:0]  shamt;
  logic [63:0] keep_mask;
  logic [63:0] pad_word;
  logic        in_acc, out_acc;

  assign in_word = in_tdata[63:0];
  assign in_cnt  = in_tdata[67:64];
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Partial last word: keep the top valid bytes, pad right after them
  assign shamt     = {in_cnt[2:0], 3'b000};
  assign keep_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> shamt);
  assign pad_word  = PAD_TOP >> shamt;

  // Round constant from the round index
  assign rnd_idx = FIRST_RND + rnd_r;
  assign rc      = {4'hF - rnd_idx, rnd_idx};

  ahe_round u_round (
    .x_in  (x_r),
    .rc    (rc),
    .x_out (x_rnd)
  );

  always_comb begin
    st_nxt    = st_r;
    after_nxt = after_r;
    rnd_nxt   = rnd_r;
    sqz_nxt   = sqz_r;
    x_nxt     = x_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt  = ST_RUN;
          rnd_nxt = '0;
          if (!in_tlast) begin
            x_nxt[0]  = x_r[0] ^ in_word;
            after_nxt = NX_IDLE;
          end else if (in_cnt[3]) begin
            // full last word: extra padding-only block follows
            x_nxt[0]  = x_r[0] ^ in_word;
            after_nxt = NX_PAD;
          end else begin
            x_nxt[0]  = x_r[0] ^ (in_word & keep_mask) ^ pad_word;
            after_nxt = NX_SQUEEZE;
          end
        end
      end
      ST_RUN: begin
        x_nxt   = x_rnd;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == LAST_RND) begin
          rnd_nxt = '0;
          case (after_r)
            NX_PAD: begin
              x_nxt[0]  = x_rnd[0] ^ PAD_TOP;
              after_nxt = NX_SQUEEZE;
            end
            NX_SQUEEZE: st_nxt = ST_OUT;
            default:    st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          st_nxt  = ST_RUN;
          rnd_nxt = '0;
          if (sqz_r == LAST_SQZ) begin
            // restart from the IV and rebuild the initialized state
            sqz_nxt   = '0;
            x_nxt     = {64'd0, 64'd0, 64'd0, 64'd0, HASH_IV};
            after_nxt = NX_IDLE;
          end else begin
            sqz_nxt   = sqz_r + 1'b1;
            after_nxt = NX_SQUEEZE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_RUN;
      after_r <= NX_IDLE;
      rnd_r   <= '0;
      sqz_r   <= '0;
      x_r     <= {64'd0, 64'd0, 64'd0, 64'd0, HASH_IV};
    end else begin
      st_r    <= st_nxt;
      after_r <= after_nxt;
      rnd_r   <= rnd_nxt;
      sqz_r   <= sqz_nxt;
      x_r     <= x_nxt;
    end
  end

  // Digest word is read straight from the registered rate word
  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = x_r[0];
  assign out_tlast  = (sqz_r == LAST_SQZ);

  // Never take an item while a digest word is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");

  // A non-last word never produces a digest word right away
  a_nolast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tlast) |=> !out_tvalid)
    else $error("digest after non-last word");

  // Final digest word starts re-initialization, input stays closed
  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (!in_tready && rnd_r == '0))
    else $error("no re-init after last digest word");

  // Round counter stays in range
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= LAST_RND)
    else $error("round counter out of range");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Ascon-Hash engine with a digest predictor and stream drivers.

module testbench;
  import ahe_pkg::*;

  class ascon_digest_board;
    sponge_t     sponge;
    logic [63:0] digest_q[$];
    bit          digest_last_q[$];
    int          mismatches;
    int          words_checked;
    int          messages;

    function new();
      mismatches    = 0;
      words_checked = 0;
      messages      = 0;
      init_sponge();
    endfunction

    function logic [63:0] rotr(logic [63:0] v, int unsigned n);
      return (v >> n) | (v << (64 - n));
    endfunction

    function void apply_round(logic [63:0] rc);
      logic [63:0] t0, t1, t2, t3, t4;
      sponge[2] ^= rc;
      sponge[0] ^= sponge[4];
      sponge[4] ^= sponge[3];
      sponge[2] ^= sponge[1];
      t0 = ~sponge[0] & sponge[1];
      t1 = ~sponge[1] & sponge[2];
      t2 = ~sponge[2] & sponge[3];
      t3 = ~sponge[3] & sponge[4];
      t4 = ~sponge[4] & sponge[0];
      sponge[0] ^= t1;
      sponge[1] ^= t2;
      sponge[2] ^= t3;
      sponge[3] ^= t4;
      sponge[4] ^= t0;
      sponge[1] ^= sponge[0];
      sponge[0] ^= sponge[4];
      sponge[3] ^= sponge[2];
      sponge[2] = ~sponge[2];
      sponge[0] ^= rotr(sponge[0], 19) ^ rotr(sponge[0], 28);
      sponge[1] ^= rotr(sponge[1], 61) ^ rotr(sponge[1], 39);
      sponge[2] ^= rotr(sponge[2], 1) ^ rotr(sponge[2], 6);
      sponge[3] ^= rotr(sponge[3], 10) ^ rotr(sponge[3], 17);
      sponge[4] ^= rotr(sponge[4], 7) ^ rotr(sponge[4], 41);
    endfunction

    function void permute();
      int idx;
      for (int r = 0; r < PERM_ROUNDS; r++) begin
        idx = TOTAL_ROUNDS - PERM_ROUNDS + r;
        apply_round(64'(((15 - idx) << 4) | idx));
      end
    endfunction

    function void init_sponge();
      sponge[0] = HASH_IV;
      sponge[1] = '0;
      sponge[2] = '0;
      sponge[3] = '0;
      sponge[4] = '0;
      permute();
    endfunction

    // Absorb one accepted word; a last word queues the whole digest.
    function void absorb(logic [63:0] word, logic [3:0] count, bit last);
      if (!last) begin
        sponge[0] ^= word;
        permute();
        return;
      end
      if (count >= 8) begin
        // full last word: its own block, then a padding-only block
        sponge[0] ^= word;
        permute();
        sponge[0] ^= PAD_TOP;
      end else begin
        if (count != 0)
          sponge[0] ^= word & ~({64{1'b1}} >> (8 * count));
        sponge[0] ^= PAD_TOP >> (8 * count);
      end
      permute();
      for (int k = 0; k < DIGEST_WORDS; k++) begin
        digest_q.push_back(sponge[0]);
        digest_last_q.push_back(k == DIGEST_WORDS - 1);
        if (k < DIGEST_WORDS - 1)
          permute();
      end
      init_sponge();
      messages++;
    endfunction

    function void check_word(logic [63:0] data, logic last);
      logic [63:0] exp_word;
      bit          exp_last;
      if (digest_q.size() == 0) begin
        $error("hash_word: no digest word pending, got %h", data);
        mismatches++;
        return;
      end
      exp_word = digest_q.pop_front();
      exp_last = digest_last_q.pop_front();
      if (data !== exp_word) begin
        $error("hash_word: expected %h, got %h", exp_word, data);
        mismatches++;
      end
      if (last !== exp_last) begin
        $error("hash_last: expected %0b, got %0b", exp_last, last);
        mismatches++;
      end
      words_checked++;
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 270;
  localparam int QUIET_AFTER  = 210;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 24;
  localparam int LIMIT_CYCLES = 200000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // [63:0] message_word, [67:64] byte_count, [71:68] zero
  logic        in_tlast   = 1'b0; // last_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // [63:0] hash_word
  logic        out_tlast;         // hash_last

  ascon_digest_board board;
  bit quiet;
  int items_sent;
  int directed_items;
  int cycles;

  ascon_hash_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_word(out_tdata, out_tlast);
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one item, hold it until taken, then maybe idle for a burst.
  task automatic send_word(logic [63:0] word, logic [3:0] count, bit last);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, count, word};
    in_tlast  <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    board.absorb(word, count, last);
    items_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {4'b0, 4'($urandom), $urandom, $urandom};
      in_tlast  <= 1'($urandom);
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_random_message();
    int          body_len;
    int          pick;
    logic [3:0]  cnt;
    body_len = $urandom_range(0, 5);
    if ($urandom_range(0, 9) == 0)
      body_len = $urandom_range(6, 12);
    for (int k = 0; k < body_len; k++) begin
      // count on a body word is don't-care; mostly send a proper 8
      cnt = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd8;
      send_word(rand_word(), cnt, 1'b0);
    end
    pick = $urandom_range(0, 9);
    if (pick < 7)
      cnt = 4'($urandom_range(0, 7));
    else if (pick < 9)
      cnt = 4'd8;
    else
      cnt = 4'($urandom_range(9, 15));
    send_word(rand_word(), cnt, 1'b1);
  endtask

  initial begin : stimulus
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message: padding only
    send_word(64'h0123_4567_89ab_cdef, 4'd0, 1'b1);
    // full last words need the extra padding block
    send_word('1, 4'd8, 1'b1);
    send_word('0, 4'd8, 1'b1);
    // counts above eight saturate
    send_word('1, 4'd15, 1'b1);
    send_word(rand_word(), 4'd9, 1'b1);
    // body word counts are ignored
    send_word('1, 4'd0, 1'b0);
    send_word('0, 4'd15, 1'b0);
    send_word('1, 4'd7, 1'b1);
    // partial last words with every bit set below the valid bytes
    for (int c = 1; c <= 6; c++)
      send_word('1, 4'(c), 1'b1);
    send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word({$urandom, $urandom}, 4'd3, 1'b1);
    directed_items = items_sent;

    while (items_sent < directed_items + RANDOM_ITEMS) begin
      if (items_sent - directed_items >= QUIET_AFTER)
        quiet = 1'b1;
      send_random_message();
    end
    in_tvalid <= 1'b0;

    while (board.pending() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d items (%0d directed) in %0d messages, %0d digest words checked",
             items_sent, directed_items, board.messages, board.words_checked);
    $display("one %0d-cycle output hold-off with the input backed up", HOLD_CYCLES);
    if (board.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : receiver
    bit held;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held && board.words_checked >= HOLD_AT) begin
        // long hold-off: the engine stalls with a digest word waiting
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end
endmodule
